>>> design/hit_overlap_dedup_macros.svh
// Assertion macros for the hit overlap dedup block.
`ifndef HIT_OVERLAP_DEDUP_MACROS_SVH
`define HIT_OVERLAP_DEDUP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HOD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define HOD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`else

`define HOD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define HOD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> design/hod_pkg.sv
// Shared constants and types for the hit overlap dedup block.
`timescale 1ns / 1ps

package hod_pkg;

  localparam int MAX_HITS  = 64;
  localparam int HIT_AW    = $clog2(MAX_HITS);
  localparam int CNT_W     = HIT_AW + 1;

  localparam int REF_W     = 16;
  localparam int POS_W     = 32;
  localparam int LEN_W     = 16;
  localparam int GAP_W     = 20;
  localparam int FRAC_W    = 16;
  localparam int WIN_W     = GAP_W + 1;
  localparam int PROD_W    = FRAC_W + LEN_W;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_GAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FRAC  = CFG_IDX_W'(1);

  localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(10000);
  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(62259);

  typedef struct packed {
    logic [REF_W-1:0] ref_id;
    logic             strand_rev;
    logic [POS_W-1:0] position;
  } hit_t;

  typedef struct packed {
    logic excl;
    hit_t hit;
  } entry_t;

  typedef struct packed {
    logic in_window;
    logic overlap;
  } cmp_t;

endpackage

>>> design/hod_hit_ram.sv
// Hit store: one write port, one registered read port.
`timescale 1ns / 1ps

module hod_hit_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [hod_pkg::HIT_AW-1:0]  waddr,
  input  hod_pkg::entry_t             wdata,
  input  logic                        re,
  input  logic [hod_pkg::HIT_AW-1:0]  raddr,
  output hod_pkg::entry_t             rd_data
);

  hod_pkg::entry_t mem [hod_pkg::MAX_HITS];
  hod_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/hod_cmp.sv
// Window and overlap test of a later hit against an earlier one.
`timescale 1ns / 1ps

module hod_cmp (
  input  hod_pkg::hit_t                  p_hit,
  input  hod_pkg::hit_t                  q_hit,
  input  logic [hod_pkg::LEN_W-1:0]      len,
  input  logic [hod_pkg::WIN_W-1:0]      len_gap,
  input  logic [hod_pkg::PROD_W-1:0]     thr_prod,
  output hod_pkg::cmp_t                  res
);

  logic [hod_pkg::POS_W:0]   win_end;
  logic [hod_pkg::POS_W+1:0] diff;
  logic                      diff_pos;
  logic                      diff_big;
  logic                      diff_gt;

  always_comb begin
    win_end  = (hod_pkg::POS_W+1)'(q_hit.position) + (hod_pkg::POS_W+1)'(len_gap);
    diff     = (hod_pkg::POS_W+2)'(q_hit.position) + (hod_pkg::POS_W+2)'(len)
             - (hod_pkg::POS_W+2)'(p_hit.position);
    diff_pos = !diff[hod_pkg::POS_W+1] && (diff != '0);
    // diff of 2^LEN_W or more always beats the product
    diff_big = |diff[hod_pkg::POS_W:hod_pkg::LEN_W];
    diff_gt  = {diff[hod_pkg::LEN_W-1:0], hod_pkg::FRAC_W'(0)} > thr_prod;

    res.in_window = (p_hit.ref_id == q_hit.ref_id)
                 && (p_hit.strand_rev == q_hit.strand_rev)
                 && ((hod_pkg::POS_W+1)'(p_hit.position) < win_end);
    res.overlap   = diff_pos && (diff_big || diff_gt);
  end

endmodule

>>> design/hit_overlap_dedup.sv
// Hit overlap dedup top level: load, backward scan over the hit store, emit.
// Load: one hit word per cycle; the set closes on the last hit.
// Scan: each hit from the second on is latched, then compared with earlier hits going
//   back until one is excluded or out of window; each compare is a store read-modify-write.
// Emit: stored hits are read in order, excluded ones skipped; stalls only on a busy output register.
// Reset: count cleared, chain_gap 10000, fraction 62259; store not cleared.
`timescale 1ns / 1ps

`include "hit_overlap_dedup_macros.svh"

module hit_overlap_dedup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hod_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hod_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hod_pkg::REF_W-1:0]       in_ref_id,
  input  logic                            in_strand_rev,
  input  logic [hod_pkg::POS_W-1:0]       in_position,
  input  logic [hod_pkg::LEN_W-1:0]       in_read_len,
  input  logic                            in_last_hit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hod_pkg::REF_W-1:0]       out_kept_ref_id,
  output logic                            out_kept_strand_rev,
  output logic [hod_pkg::POS_W-1:0]       out_kept_position,
  output logic                            out_last_kept
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_S_START,
    ST_P_LATCH,
    ST_CMP,
    ST_E_START,
    ST_E_CHK,
    ST_FLUSH
  } state_t;

  state_t                        state_r, state_nxt;
  logic [hod_pkg::GAP_W-1:0]     chain_gap_r;
  logic [hod_pkg::FRAC_W-1:0]    red_frac_r;
  logic [hod_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [hod_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [hod_pkg::CNT_W-1:0]     i_r, i_nxt;
  logic [hod_pkg::CNT_W-1:0]     k_r, k_nxt;
  logic [hod_pkg::CNT_W-1:0]     e_r, e_nxt;
  logic [hod_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [hod_pkg::WIN_W-1:0]     len_gap_r, len_gap_nxt;
  logic [hod_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  hod_pkg::hit_t                 p_r, p_nxt;
  logic                          pend_valid_r, pend_valid_nxt;
  hod_pkg::hit_t                 pend_hit_r, pend_hit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  hod_pkg::hit_t                 out_hit_r, out_hit_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          mem_we, mem_re;
  logic [hod_pkg::HIT_AW-1:0]    mem_waddr, mem_raddr;
  hod_pkg::entry_t               mem_wdata, rd_data;
  hod_pkg::hit_t                 in_hit;
  hod_pkg::cmp_t                 cmp;

  logic                          in_acc, out_free, stop;
  logic [hod_pkg::CNT_W-1:0]     n_cnt, k1, i1, e1;

  hod_hit_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rd_data (rd_data)
  );

  hod_cmp u_cmp (
    .p_hit    (p_r),
    .q_hit    (rd_data.hit),
    .len      (len_r),
    .len_gap  (len_gap_r),
    .thr_prod (prod_r),
    .res      (cmp)
  );

  assign in_stall            = (state_r != ST_LOAD);
  assign out_valid           = out_valid_r;
  assign out_kept_ref_id     = out_hit_r.ref_id;
  assign out_kept_strand_rev = out_hit_r.strand_rev;
  assign out_kept_position   = out_hit_r.position;
  assign out_last_kept       = out_last_r;

  always_comb begin
    in_hit.ref_id     = in_ref_id;
    in_hit.strand_rev = in_strand_rev;
    in_hit.position   = in_position;
    in_acc   = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    stop     = rd_data.excl || !cmp.in_window;
    k1       = k_r - hod_pkg::CNT_W'(1);
    i1       = i_r + hod_pkg::CNT_W'(1);
    e1       = e_r + hod_pkg::CNT_W'(1);
    n_cnt    = cnt_r;

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    e_nxt          = e_r;
    len_nxt        = len_r;
    len_gap_nxt    = len_gap_r;
    prod_nxt       = prod_r;
    p_nxt          = p_r;
    pend_valid_nxt = pend_valid_r;
    pend_hit_nxt   = pend_hit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_last_nxt   = out_last_r;

    mem_we         = 1'b0;
    mem_waddr      = cnt_r[hod_pkg::HIT_AW-1:0];
    mem_wdata.excl = 1'b0;
    mem_wdata.hit  = in_hit;
    mem_re         = 1'b0;
    mem_raddr      = e_r[hod_pkg::HIT_AW-1:0];

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < hod_pkg::CNT_W'(hod_pkg::MAX_HITS)) begin
            mem_we  = 1'b1;
            n_cnt   = cnt_r + hod_pkg::CNT_W'(1);
            cnt_nxt = n_cnt;
          end
          if (in_last_hit) begin
            n_nxt       = n_cnt;
            cnt_nxt     = '0;
            len_nxt     = in_read_len;
            len_gap_nxt = hod_pkg::WIN_W'(in_read_len) + hod_pkg::WIN_W'(chain_gap_r);
            prod_nxt    = hod_pkg::PROD_W'(red_frac_r) * hod_pkg::PROD_W'(in_read_len);
            i_nxt       = hod_pkg::CNT_W'(1);
            state_nxt   = (n_cnt > hod_pkg::CNT_W'(1)) ? ST_S_START : ST_E_START;
          end
        end
      end
      ST_S_START: begin
        mem_re    = 1'b1;
        mem_raddr = i_r[hod_pkg::HIT_AW-1:0];
        state_nxt = ST_P_LATCH;
      end
      ST_P_LATCH: begin
        p_nxt     = rd_data.hit;
        k_nxt     = i_r;
        mem_re    = 1'b1;
        mem_raddr = i_r[hod_pkg::HIT_AW-1:0] - hod_pkg::HIT_AW'(1);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!stop && cmp.overlap) begin
          mem_we         = 1'b1;
          mem_waddr      = k1[hod_pkg::HIT_AW-1:0];
          mem_wdata.excl = 1'b1;
          mem_wdata.hit  = rd_data.hit;
        end
        if (stop || (k1 == '0)) begin
          i_nxt = i1;
          if (i1 == n_r) begin
            state_nxt = ST_E_START;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = i1[hod_pkg::HIT_AW-1:0];
            state_nxt = ST_P_LATCH;
          end
        end else begin
          k_nxt     = k1;
          mem_re    = 1'b1;
          mem_raddr = k1[hod_pkg::HIT_AW-1:0] - hod_pkg::HIT_AW'(1);
        end
      end
      ST_E_START: begin
        e_nxt     = '0;
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = ST_E_CHK;
      end
      ST_E_CHK: begin
        if (rd_data.excl || !pend_valid_r || out_free) begin
          if (!rd_data.excl) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = pend_hit_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_hit_nxt   = rd_data.hit;
          end
          e_nxt = e1;
          if (e1 == n_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = e1[hod_pkg::HIT_AW-1:0];
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_LOAD;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = pend_hit_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      chain_gap_r  <= hod_pkg::GAP_RESET;
      red_frac_r   <= hod_pkg::FRAC_RESET;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we && (cfg_index == hod_pkg::CFG_CHAIN_GAP)) begin
        chain_gap_r <= cfg_wdata[hod_pkg::GAP_W-1:0];
      end
      if (cfg_we && (cfg_index == hod_pkg::CFG_RED_FRAC)) begin
        red_frac_r <= cfg_wdata[hod_pkg::FRAC_W-1:0];
      end
    end
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    e_r        <= e_nxt;
    len_r      <= len_nxt;
    len_gap_r  <= len_gap_nxt;
    prod_r     <= prod_nxt;
    p_r        <= p_nxt;
    pend_hit_r <= pend_hit_nxt;
    out_hit_r  <= out_hit_nxt;
    out_last_r <= out_last_nxt;
  end

  `HOD_ASSERT_IMP(a_scan_k_range, clk, rst_n, state_r == ST_CMP, (k_r != '0) && (k_r <= i_r), "scan index out of range")
  `HOD_ASSERT_IMP(a_scan_i_range, clk, rst_n, (state_r == ST_P_LATCH) || (state_r == ST_CMP), (i_r != '0) && (i_r < n_r), "hit index out of range")
  `HOD_ASSERT_IMP(a_load_no_pend, clk, rst_n, state_r == ST_LOAD, !pend_valid_r, "pending word left at load")
  `HOD_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= hod_pkg::CNT_W'(hod_pkg::MAX_HITS), "hit count overflow")

endmodule
